>>> rtl/core/gcr_pkg.sv
// gcr_pkg: shared types and constants of the gap cluster range block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gcr_pkg;

    localparam int VIEW_W = 6;
    localparam int GAP_W  = 6;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register index within the configuration space
    localparam logic [0:0] REG_GAP_LIMIT = 1'b0;
    localparam logic [GAP_W-1:0] GAP_RESET = 6'd1;

    typedef logic [VIEW_W-1:0] t_view;
    typedef logic [GAP_W-1:0]  t_gap;

    // controller -> datapath
    typedef struct packed {
        logic record;  // set the bit of the incoming view
        logic start;   // open a scan at view 0
        logic step;    // examine one bitmap position
        logic finish;  // emit the open range, clear the bitmap
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic at_end;    // scan index has passed the last view
        logic need_emit; // current position closes a range
        logic open;      // a range is open
        logic out_free;  // output register can take a new item
    } t_sts;

endpackage

>>> rtl/core/gcr_view_if.sv
// gcr_view_if: input channel carrying one view per item.
// Depends on gcr_pkg for the view type.
`timescale 1ns / 1ps

interface gcr_view_if;
    logic           valid;
    logic           ready;
    gcr_pkg::t_view view;
    logic           last_view;

    modport source (output valid, output view, output last_view, input ready);
    modport sink   (input valid, input view, input last_view, output ready);
endinterface

>>> rtl/core/gcr_range_if.sv
// gcr_range_if: output channel carrying one range per item.
// Depends on gcr_pkg for the view type.
`timescale 1ns / 1ps

interface gcr_range_if;
    logic           valid;
    logic           ready;
    gcr_pkg::t_view range_low;
    gcr_pkg::t_view range_high;
    logic           last_range;

    modport source (output valid, output range_low, output range_high, output last_range,
                    input ready);
    modport sink   (input valid, input range_low, input range_high, input last_range,
                    output ready);
endinterface

>>> rtl/core/gap_cluster_ranges.sv
// gap_cluster_ranges: groups a set of views into ranges of nearby views.
// Uses gcr_pkg, gcr_view_if, gcr_range_if, gcr_ctrl and gcr_dp.
//
// Usage:
//   i_view  carries one view index per item with a last_view flag. Each view
//           sets its bit in an occupancy bitmap; duplicates merge and views at
//           or above VIEW_COUNT are dropped. Loading takes one item per cycle.
//   o_range carries (range_low, range_high, last_range) items in ascending
//           order; last_range marks the final range of the set. A set with no
//           recorded view produces no item.
//   APB     one register, gap_limit at byte address 0 (reset 1): neighboring
//           views whose distance is at most gap_limit share a range.
// Timing: after the item with last_view, i_view.ready drops and the bitmap is
//   scanned one position per cycle, all VIEW_COUNT positions, unless stalled;
//   a finish step then closes the final range and clears the bitmap. A range
//   that is closed during the scan is registered into the output register when
//   the scan steps past the view that closes it; the final range is registered
//   when the scan finishes.
// Stalls: a single output register holds each range; while full and o_range.ready
//   is low, the scan holds where a range closes, and so does the final close.
// Reset (synchronous, active low): clears the bitmap, returns to loading and
//   sets gap_limit to 1.
`timescale 1ns / 1ps

module gap_cluster_ranges #(
    parameter int VIEW_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gcr_view_if.sink                      i_view,
    gcr_range_if.source                   o_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcr_pkg::ADDR_W-1:0]    paddr,
    input  logic [gcr_pkg::DATA_W-1:0]    pwdata,
    output logic [gcr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    gcr_pkg::t_cmd cmd;
    gcr_pkg::t_sts sts;
    gcr_pkg::t_gap r_gap_limit;
    logic          reg_sel;
    logic          cfg_wr;

    // configuration: register index is paddr[2], word aligned
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == gcr_pkg::REG_GAP_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_sel ? gcr_pkg::DATA_W'(r_gap_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= gcr_pkg::GAP_RESET;
        end else if (cfg_wr && reg_sel) begin
            r_gap_limit <= pwdata[gcr_pkg::GAP_W-1:0];
        end
    end

    gcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_view.valid),
        .i_in_last  (i_view.last_view),
        .i_sts      (sts),
        .o_in_ready (i_view.ready),
        .o_cmd      (cmd)
    );

    gcr_dp #(
        .VIEW_COUNT (VIEW_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_gap       (r_gap_limit),
        .i_view      (i_view.view),
        .i_out_ready (o_range.ready),
        .o_out_valid (o_range.valid),
        .o_low       (o_range.range_low),
        .o_high      (o_range.range_high),
        .o_last      (o_range.last_range)
    );

    // at most one scan command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.step, cmd.finish}))
        else $error("more than one scan command in a cycle");

    // a range is only closed into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && sts.need_emit) || (cmd.finish && sts.open) |-> sts.out_free)
        else $error("range emitted into a full output register");

    // finishing a scan returns to loading
    a_finish_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> i_view.ready && !sts.open)
        else $error("block did not return to loading after a scan");

endmodule

>>> rtl/core/gcr_ctrl.sv
// gcr_ctrl: load/scan state machine of the gap cluster range block.
// Depends on gcr_pkg for the command and status structs.
`timescale 1ns / 1ps

module gcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  gcr_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output gcr_pkg::t_cmd o_cmd
);

    localparam logic S_LOAD = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.record = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.at_end) begin
                    // hold while a closed range has nowhere to go
                    o_cmd.step = !(i_sts.need_emit && !i_sts.out_free);
                end else if (!(i_sts.open && !i_sts.out_free)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/gcr_dp.sv
// gcr_dp: occupancy bitmap, scan counter, open range and output register.
// Depends on gcr_pkg; driven by gcr_ctrl through command and status structs.
`timescale 1ns / 1ps

module gcr_dp #(
    parameter int VIEW_COUNT = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gcr_pkg::t_cmd  i_cmd,
    output gcr_pkg::t_sts  o_sts,
    input  gcr_pkg::t_gap  i_gap,
    input  gcr_pkg::t_view i_view,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output gcr_pkg::t_view o_low,
    output gcr_pkg::t_view o_high,
    output logic           o_last
);

    localparam int IW = $clog2(VIEW_COUNT);
    localparam int CW = $clog2(VIEW_COUNT + 1);

    logic [VIEW_COUNT-1:0] r_bitmap, n_bitmap;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_open, n_open;
    gcr_pkg::t_view        r_lo, n_lo;
    gcr_pkg::t_view        r_hi, n_hi;
    logic                  r_out_valid, n_out_valid;
    gcr_pkg::t_view        r_out_low, n_out_low;
    gcr_pkg::t_view        r_out_high, n_out_high;
    logic                  r_out_last, n_out_last;

    logic                  bit_set;
    gcr_pkg::t_view        cur_view;
    gcr_pkg::t_view        gap_dist;

    assign cur_view = gcr_pkg::VIEW_W'(r_idx[IW-1:0]);
    assign bit_set  = r_bitmap[r_idx[IW-1:0]];
    assign gap_dist = cur_view - r_hi;

    assign o_sts.at_end    = (r_idx == CW'(VIEW_COUNT));
    assign o_sts.need_emit = bit_set && r_open && (gap_dist > i_gap);
    assign o_sts.open      = r_open;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_bitmap    = r_bitmap;
        n_idx       = r_idx;
        n_open      = r_open;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        n_out_last  = r_out_last;

        // views at or above VIEW_COUNT shift out of the bitmap and drop
        if (i_cmd.record) begin
            n_bitmap = r_bitmap | (VIEW_COUNT'(1) << i_view);
        end
        if (i_cmd.start) begin
            n_idx  = '0;
            n_open = 1'b0;
        end
        if (i_cmd.step) begin
            n_idx = r_idx + CW'(1);
            if (bit_set) begin
                if (o_sts.need_emit) begin
                    n_out_valid = 1'b1;
                    n_out_low   = r_lo;
                    n_out_high  = r_hi;
                    n_out_last  = 1'b0;
                end
                if (!r_open || o_sts.need_emit) begin
                    n_lo = cur_view;
                end
                n_hi   = cur_view;
                n_open = 1'b1;
            end
        end
        if (i_cmd.finish) begin
            if (r_open) begin
                n_out_valid = 1'b1;
                n_out_low   = r_lo;
                n_out_high  = r_hi;
                n_out_last  = 1'b1;
            end
            n_open   = 1'b0;
            n_bitmap = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap    <= '0;
            r_idx       <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bitmap    <= n_bitmap;
            r_idx       <= n_idx;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_low       = r_out_low;
    assign o_high      = r_out_high;
    assign o_last      = r_out_last;

endmodule
